/* rtl/swb_pkg.sv */
// ----------------------------------------------------------------------------
// swb_pkg
// Shared types and constants for the combined subtract-with-borrow and
// congruential uniform random generator.
// ----------------------------------------------------------------------------
package swb_pkg;

    // Default number of discarded warm-up steps after a reseed
    localparam int unsigned JUMP_STEPS_DEF = 10;

    // Congruential step constants
    localparam logic [31:0] LCG_MUL = 32'd69069;
    localparam logic [31:0] LCG_ADD = 32'd1013904243;

    // Subtract-with-borrow constants
    localparam logic [31:0] SWB_SUB   = 32'd18;
    localparam logic [31:0] LAG1_INIT = 32'd6334;
    localparam logic [31:0] LAG2_INIT = 32'd18467;
    localparam logic [31:0] LAG3_INIT = 32'd41;

    // Request action codes
    localparam logic ACT_DRAW   = 1'b0;
    localparam logic ACT_RESEED = 1'b1;

    // Configuration register indexes
    localparam logic CFG_RANGE_LOW  = 1'b0;
    localparam logic CFG_RANGE_HIGH = 1'b1;

    // Reset values of the range registers
    localparam logic signed [31:0] RANGE_LOW_RST  = 32'sh8000_0000;
    localparam logic signed [31:0] RANGE_HIGH_RST = 32'sh7FFF_FFFF;

    // Controller states
    typedef enum logic [2:0] {
        ST_SEED,
        ST_IDLE,
        ST_JUMP,
        ST_DRAW,
        ST_MUL,
        ST_FIN
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // load lag constants, borrow and seed
        logic seed_zero;  // use zero in place of the request seed
        logic advance;    // step both generators, capture the sum
        logic mul;        // multiply the sum by the range span
        logic out_load;   // load the result register
    } t_cmd;

endpackage

/* rtl/swb_lcg_uniform_random_core.sv */
// ----------------------------------------------------------------------------
// swb_lcg_uniform_random_core
// Uniform random generator: lag-3 subtract-with-borrow plus 32-bit
// congruential sequence, summed and scaled into a configurable range.
//
//  Channel   Signals                              Direction  Carries
//  in        i_in_valid/o_in_ready, i_action,     in         draw or reseed
//            i_seed
//  out       o_out_valid/i_out_ready, o_value,    out        one per draw
//            o_raw_sum, o_lcg_now
//  cfg       i_cfg_we, i_cfg_idx, i_cfg_data      in         range registers
//
//  A draw runs these steps after acceptance: generator step, span
//  multiply, then rounding and saturation into the result register;
//  the next request is taken after the result register is loaded.
//  A reseed loads the seed, then runs JUMP_STEPS warm-up steps, one per cycle.
//  After reset the block runs a seed-zero reseed and accepts no request
//  until it ends; configuration writes are taken.
//  A result held by the consumer stalls the next draw in its last step.
// ----------------------------------------------------------------------------
module swb_lcg_uniform_random_core
    import swb_pkg::*;
#(
    parameter int unsigned JUMP_STEPS = JUMP_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic        [31:0] i_seed,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    output logic signed [31:0] o_raw_sum,
    output logic        [31:0] o_lcg_now,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic        [31:0] i_cfg_data
);

    t_cmd s_cmd;

    swb_ctrl #(
        .JUMP_STEPS (JUMP_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (s_cmd)
    );

    swb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (s_cmd),
        .i_seed     (i_seed),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_value    (o_value),
        .o_raw_sum  (o_raw_sum),
        .o_lcg_now  (o_lcg_now)
    );

    // A result must never overwrite one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten while held");

    // An accepted draw occupies the block on the next cycle
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_action == ACT_DRAW)) |=> !o_in_ready)
        else $error("request accepted during a draw");

    // A reseed with warm-up steps occupies the block on the next cycle
    a_reseed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_action == ACT_RESEED) && (JUMP_STEPS != 0))
        |=> !o_in_ready)
        else $error("request accepted during warm-up");

    // At most one datapath operation per cycle
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_cmd.load, s_cmd.advance, s_cmd.mul, s_cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule

/* rtl/swb_ctrl.sv */
// ----------------------------------------------------------------------------
// swb_ctrl
// Sequencer: power-up warm-up, request handshake, reseed jump count,
// draw steps and result valid.
// ----------------------------------------------------------------------------
module swb_ctrl
    import swb_pkg::*;
#(
    parameter int unsigned JUMP_STEPS = JUMP_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_action,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam int unsigned CNT_W = (JUMP_STEPS > 0) ? $clog2(JUMP_STEPS + 1) : 1;
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(JUMP_STEPS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;

    // State, jump count and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SEED;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_SEED: begin
                o_cmd.load      = 1'b1;
                o_cmd.seed_zero = 1'b1;
                n_cnt           = CNT_LOAD;
                n_state         = (JUMP_STEPS > 0) ? ST_JUMP : ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_RESEED) begin
                        o_cmd.load = 1'b1;
                        n_cnt      = CNT_LOAD;
                        n_state    = (JUMP_STEPS > 0) ? ST_JUMP : ST_IDLE;
                    end else begin
                        n_state = ST_DRAW;
                    end
                end
            end
            ST_JUMP: begin
                // Run discarded steps, leave after the last one
                o_cmd.advance = 1'b1;
                n_cnt         = r_cnt - CNT_ONE;
                if (r_cnt == CNT_ONE) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAW: begin
                o_cmd.advance = 1'b1;
                n_state       = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                // Hold until the result register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/swb_dp.sv */
// ----------------------------------------------------------------------------
// swb_dp
// Datapath: generator state, range registers, span multiplier, rounding,
// saturation and result register.
// ----------------------------------------------------------------------------
module swb_dp
    import swb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic        [31:0] i_seed,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic        [31:0] i_cfg_data,
    output logic signed [31:0] o_value,
    output logic signed [31:0] o_raw_sum,
    output logic        [31:0] o_lcg_now
);

    localparam int unsigned P_W = 65;  // span product
    localparam int unsigned A_W = 66;  // product plus centre offset
    localparam int unsigned F_W = A_W - 32;

    logic        [31:0]    r_lag_one, r_lag_two, r_lag_three, r_lcg;
    logic                  r_borrow;
    logic signed [31:0]    r_range_low, r_range_high;
    logic signed [31:0]    r_sum;
    logic signed [P_W-1:0] r_prod;
    logic signed [31:0]    r_value, r_raw_sum;
    logic        [31:0]    r_lcg_now;

    logic        [31:0]    w_diff, w_swb, w_lcg_next;
    logic                  w_borrow_next;
    logic signed [32:0]    w_lo, w_hi, w_span, w_mid2, w_mn, w_mx;
    logic signed [A_W-1:0] w_acc;
    logic signed [F_W-1:0] w_floor, w_round, w_mn_x, w_mx_x, w_sat;
    logic        [31:0]    w_rem;
    logic                  w_up;

    // Range registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= RANGE_LOW_RST;
            r_range_high <= RANGE_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                CFG_RANGE_HIGH: r_range_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Subtract-with-borrow step: a non-positive result takes 18 more off
    always_comb begin
        w_diff = r_lag_two - r_lag_three - {31'd0, r_borrow};
        if ((w_diff != '0) && !w_diff[31]) begin
            w_swb         = w_diff;
            w_borrow_next = 1'b0;
        end else begin
            w_swb         = w_diff - SWB_SUB;
            w_borrow_next = 1'b1;
        end
    end

    assign w_lcg_next = r_lcg * LCG_MUL + LCG_ADD;

    // Generator state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lag_one   <= LAG1_INIT;
            r_lag_two   <= LAG2_INIT;
            r_lag_three <= LAG3_INIT;
            r_borrow    <= 1'b1;
            r_lcg       <= i_cmd.seed_zero ? '0 : i_seed;
        end else if (i_cmd.advance) begin
            r_lag_one   <= w_swb;
            r_lag_two   <= r_lag_one;
            r_lag_three <= r_lag_two;
            r_borrow    <= w_borrow_next;
            r_lcg       <= w_lcg_next;
            r_sum       <= w_swb + w_lcg_next;
        end
    end

    assign w_lo   = 33'(r_range_low);
    assign w_hi   = 33'(r_range_high);
    assign w_span = w_hi - w_lo;
    assign w_mid2 = w_hi + w_lo;
    assign w_mn   = (w_lo < w_hi) ? w_lo : w_hi;
    assign w_mx   = (w_lo < w_hi) ? w_hi : w_lo;

    // Scale the sum by the span
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= P_W'(r_sum) * P_W'(w_span);
        end
    end

    // Add (lo+hi) times 2^31, split into floor and remainder, round half away
    assign w_acc   = A_W'(r_prod) + A_W'($signed({w_mid2, 31'd0}));
    assign w_floor = w_acc[A_W-1:32];
    assign w_rem   = w_acc[31:0];
    assign w_up    = w_floor[F_W-1] ? (w_rem[31] && (w_rem[30:0] != '0)) : w_rem[31];
    assign w_round = w_floor + F_W'(w_up);
    assign w_mn_x  = F_W'(w_mn);
    assign w_mx_x  = F_W'(w_mx);

    // Saturate to the range
    always_comb begin
        w_sat = w_round;
        if (w_round < w_mn_x) begin
            w_sat = w_mn_x;
        end else if (w_round > w_mx_x) begin
            w_sat = w_mx_x;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_value   <= w_sat[31:0];
            r_raw_sum <= r_sum;
            r_lcg_now <= r_lcg;
        end
    end

    assign o_value   = r_value;
    assign o_raw_sum = r_raw_sum;
    assign o_lcg_now = r_lcg_now;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the combined subtract-with-borrow and congruential
// uniform generator. A scoreboard class keeps its own copy of both generators
// and of the range registers. It predicts each draw when the request is
// accepted and checks value, raw sum and congruential state as results
// leave the block. Requests and results are paced by random gaps and stalls,
// and the range is reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench
    import swb_pkg::*;
();

    localparam int unsigned WARMUP_STEPS    = 10;
    localparam int unsigned SETTLE_CYCLES   = WARMUP_STEPS + 8;
    localparam int          RANDOM_REQUESTS = 950;
    localparam longint      CYCLE_LIMIT     = 400000;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

    // Generator constants for the predictor
    localparam logic [31:0] CONG_MULT  = 32'd69069;
    localparam logic [31:0] CONG_INCR  = 32'd1013904243;
    localparam logic [31:0] BORROW_SUB = 32'd18;
    localparam logic [31:0] NEWEST_SET = 32'd6334;
    localparam logic [31:0] MIDDLE_SET = 32'd18467;
    localparam logic [31:0] OLDEST_SET = 32'd41;

    typedef struct {
        logic signed [31:0] value;
        logic signed [31:0] raw_sum;
        logic        [31:0] lcg_now;
    } t_draw_result;

    // ------------------------------------------------------------------------
    // Scoreboard: generator copy, range copy and queue of predicted draws
    // ------------------------------------------------------------------------
    class swb_draw_book;
        logic        [31:0] swb_newest;
        logic        [31:0] swb_middle;
        logic        [31:0] swb_oldest;
        logic               carry;
        logic        [31:0] cong_state;
        logic signed [31:0] range_lo;
        logic signed [31:0] range_hi;
        t_draw_result       expected_draws[$];
        int                 mismatches;
        int                 draws_checked;
        int                 reseeds_seen;

        function new();
            range_lo      = S32_MIN;
            range_hi      = S32_MAX;
            mismatches    = 0;
            draws_checked = 0;
            reseeds_seen  = 0;
            warm_restart(32'd0);
        endfunction

        // Step both generators once and return the wrapped sum
        function logic [31:0] step_generators();
            logic [31:0] diff;
            diff = swb_middle - swb_oldest - {31'd0, carry};
            if (diff != 32'd0 && !diff[31]) begin
                carry = 1'b0;
            end else begin
                diff  = diff - BORROW_SUB;
                carry = 1'b1;
            end
            swb_oldest = swb_middle;
            swb_middle = swb_newest;
            swb_newest = diff;
            cong_state = cong_state * CONG_MULT + CONG_INCR;
            return diff + cong_state;
        endfunction

        // Reload the lags, set the borrow, load the seed and discard warm-up
        function void warm_restart(logic [31:0] seed_val);
            swb_newest = NEWEST_SET;
            swb_middle = MIDDLE_SET;
            swb_oldest = OLDEST_SET;
            carry      = 1'b1;
            cong_state = seed_val;
            repeat (WARMUP_STEPS) void'(step_generators());
        endfunction

        // Exact (lo+hi)/2 + sum*(hi-lo)/2^32, half away from zero, clamped
        function logic signed [31:0] map_to_range(logic signed [31:0] sum);
            logic signed [95:0] lo_w;
            logic signed [95:0] hi_w;
            logic signed [95:0] sum_w;
            logic signed [95:0] numer;
            logic signed [95:0] whole;
            logic signed [95:0] lower;
            logic signed [95:0] upper;
            logic        [31:0] frac;
            lo_w  = range_lo;
            hi_w  = range_hi;
            sum_w = sum;
            numer = ((lo_w + hi_w) <<< 31) + sum_w * (hi_w - lo_w);
            whole = numer >>> 32;
            frac  = numer[31:0];
            if (!whole[95]) begin
                if (frac >= 32'h8000_0000) whole = whole + 96'sd1;
            end else begin
                if (frac > 32'h8000_0000) whole = whole + 96'sd1;
            end
            lower = (lo_w < hi_w) ? lo_w : hi_w;
            upper = (lo_w < hi_w) ? hi_w : lo_w;
            if (whole < lower) whole = lower;
            if (whole > upper) whole = upper;
            return whole[31:0];
        endfunction

        function void write_range(logic idx, logic [31:0] data);
            if (idx == CFG_RANGE_LOW) begin
                range_lo = data;
            end else begin
                range_hi = data;
            end
        endfunction

        // Note an accepted request: reseed now, or predict one draw
        function void note_request(logic act, logic [31:0] seed_val);
            logic [31:0]  sum;
            t_draw_result want;
            if (act == ACT_RESEED) begin
                warm_restart(seed_val);
                reseeds_seen++;
                return;
            end
            sum          = step_generators();
            want.raw_sum = sum;
            want.value   = map_to_range(sum);
            want.lcg_now = cong_state;
            expected_draws.push_back(want);
        endfunction

        // Compare one delivered result with the oldest prediction
        function void check_result(logic signed [31:0] value, logic signed [31:0] raw_sum,
                                   logic [31:0] lcg_now);
            t_draw_result want;
            if (expected_draws.size() == 0) begin
                $display("%0t: result with no draw outstanding: value %0d raw_sum %0d lcg_now %h",
                         $time, value, raw_sum, lcg_now);
                mismatches++;
                return;
            end
            want = expected_draws.pop_front();
            draws_checked++;
            if (value !== want.value) begin
                $display("%0t: value mismatch: expected %0d, actual %0d",
                         $time, want.value, value);
                mismatches++;
            end
            if (raw_sum !== want.raw_sum) begin
                $display("%0t: raw_sum mismatch: expected %0d, actual %0d",
                         $time, want.raw_sum, raw_sum);
                mismatches++;
            end
            if (lcg_now !== want.lcg_now) begin
                $display("%0t: lcg_now mismatch: expected %h, actual %h",
                         $time, want.lcg_now, lcg_now);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_draws.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_action;
    logic        [31:0] i_seed;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_value;
    logic signed [31:0] o_raw_sum;
    logic        [31:0] o_lcg_now;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic        [31:0] i_cfg_data;

    swb_draw_book book;
    bit           steady;
    int           stall_left;
    int           ranges_applied;
    longint       cycle_count;

    swb_lcg_uniform_random_core #(
        .JUMP_STEPS (WARMUP_STEPS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_seed      (i_seed),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_raw_sum   (o_raw_sum),
        .o_lcg_now   (o_lcg_now),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one; none in steady phases
    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_range(output logic signed [31:0] lo, output logic signed [31:0] hi);
        case ($urandom_range(0, 11))
            0: begin
                lo = S32_MIN; hi = S32_MAX;
            end
            1: begin
                lo = S32_MAX; hi = S32_MIN;
            end
            2: begin
                lo = S32_MIN; hi = S32_MIN;
            end
            3: begin
                lo = S32_MAX; hi = S32_MAX;
            end
            4: begin
                lo = $urandom; hi = lo;
            end
            5, 6, 7: begin
                lo = $urandom;
                hi = lo + $urandom_range(0, 2000) - 1000;
            end
            default: begin
                lo = $urandom; hi = $urandom;
            end
        endcase
    endtask

    // Receiver: stall at random, mostly briefly
    always @(posedge i_clk) begin
        if (steady) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30)
                                                     : $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watch both handshakes; check results before noting the new request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) book.check_result(o_value, o_raw_sum, o_lcg_now);
            if (i_in_valid && o_in_ready) book.note_request(i_action, i_seed);
        end
    end

    // Give up on a hung block
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: timeout after %0d cycles", cycle_count);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Present one request and hold it until accepted; valid stays high after
    task automatic send_request(input logic act, input logic [31:0] seed_val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_seed     <= seed_val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic run_draws(input int count);
        repeat (count) send_request(ACT_DRAW, $urandom);
    endtask

    // Hold the sender until every draw is out and a reseed would be done
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (book.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reprogram both range registers while the block is idle
    task automatic apply_range(input logic signed [31:0] lo, input logic signed [31:0] hi);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RANGE_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RANGE_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        book.write_range(CFG_RANGE_LOW, lo);
        book.write_range(CFG_RANGE_HIGH, hi);
        ranges_applied++;
    endtask

    initial begin : stimulus
        int                 remaining;
        int                 phase_len;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        book           = new();
        steady         = 1'b0;
        stall_left     = 0;
        ranges_applied = 0;
        cycle_count    = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = ACT_DRAW;
        i_seed         = 32'd0;
        i_out_ready    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_RANGE_LOW;
        i_cfg_data     = 32'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset range, seed extremes, a seed-zero reseed
        run_draws(3);
        send_request(ACT_RESEED, 32'hFFFF_FFFF);
        run_draws(2);
        send_request(ACT_RESEED, 32'h8000_0000);
        run_draws(1);
        send_request(ACT_RESEED, 32'h7FFF_FFFF);
        run_draws(1);
        send_request(ACT_RESEED, 32'h0000_0000);
        run_draws(1);

        // Directed: reversed full range, single-point ranges, narrow spans
        apply_range(S32_MAX, S32_MIN);
        run_draws(2);
        apply_range(S32_MIN, S32_MIN);
        run_draws(1);
        apply_range(S32_MAX, S32_MAX);
        run_draws(1);
        apply_range(32'sd0, 32'sd1);
        send_request(ACT_RESEED, 32'h5555_AAAA);
        run_draws(2);
        apply_range(32'sd5, -32'sd5);
        run_draws(2);

        // Random phases, each under its own range setting
        remaining = RANDOM_REQUESTS;
        while (remaining > 0) begin
            pick_range(lo, hi);
            apply_range(lo, hi);
            steady    <= ($urandom_range(0, 4) == 0);
            phase_len  = $urandom_range(20, 120);
            if (phase_len > remaining) phase_len = remaining;
            repeat (phase_len) begin
                if ($urandom_range(0, 59) == 0) wait_drained();
                if ($urandom_range(0, 11) == 0) begin
                    send_request(ACT_RESEED, pick_seed());
                end else begin
                    send_request(ACT_DRAW, $urandom);
                end
            end
            remaining = remaining - phase_len;
        end

        wait_drained();
        $display("summary: %0d draws checked, %0d reseeds, %0d range settings incl. extremes",
                 book.draws_checked, book.reseeds_seen, ranges_applied);
        $display("summary: %0d mismatches, %0d draws still outstanding",
                 book.mismatches, book.outstanding());
        if (book.mismatches == 0 && book.outstanding() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/swb_pkg.sv
rtl/swb_ctrl.sv
rtl/swb_dp.sv
rtl/swb_lcg_uniform_random_core.sv
bench/testbench.sv
